// File: hw/rtl/tldr_pkg.sv
package tldr_pkg;

    localparam int VERTEX_COUNT = 65536;
    localparam int VTX_W = 16;
    localparam int ADDR_W = $clog2(VERTEX_COUNT);
    localparam int TIME_W = 31;
    localparam int STORE_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [STORE_W-1:0] UNSET_TIME = -(32'sh7FFFFFFF / 2);

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_RELAX = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 2'd2;

    typedef struct packed {
        logic capture;
        logic sweep;
        logic load_target;
        logic eval;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
    } status_t;

endpackage

// File: hw/rtl/tldr_ctrl.sv
module tldr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          kind,
    input  tldr_pkg::status_t   status,
    output tldr_pkg::cmd_t      cmd,
    output logic                busy,
    output logic                done
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_EVAL  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   load_target_reg;
    logic   load_target_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        load_target_next = load_target_reg;
        done_next = 1'b0;
        cmd = '0;
        cmd.load_target = load_target_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (kind == tldr_pkg::KIND_BEGIN)
                    begin
                        state_next = ST_SWEEP;
                        load_target_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                    done_next = load_target_reg;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            load_target_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            load_target_reg <= load_target_next;
            done_reg <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// File: hw/rtl/tldr_datapath.sv
module tldr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tldr_pkg::cmd_t                      cmd,
    output tldr_pkg::status_t                   status,
    input  logic                                cfg_write,
    input  logic [tldr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tldr_pkg::TIME_W-1:0]         cfg_data,
    input  logic [1:0]                          kind,
    input  logic [tldr_pkg::VTX_W-1:0]          source_vertex,
    input  logic [tldr_pkg::VTX_W-1:0]          dest_vertex,
    input  logic [tldr_pkg::TIME_W-1:0]         edge_departure,
    input  logic [tldr_pkg::TIME_W-1:0]         edge_arrival,
    output logic                                joins_frontier,
    output logic signed [tldr_pkg::STORE_W-1:0] vertex_time
);

    localparam int ENTRY_W = tldr_pkg::STORE_W + 1;

    logic [ENTRY_W-1:0] mem [tldr_pkg::VERTEX_COUNT];

    logic [tldr_pkg::VTX_W-1:0]  target_reg;
    logic [tldr_pkg::TIME_W-1:0] win_start_reg;
    logic [tldr_pkg::TIME_W-1:0] win_end_reg;

    logic [1:0]                  kind_reg;
    logic [tldr_pkg::VTX_W-1:0]  dst_reg;
    logic [tldr_pkg::TIME_W-1:0] dep_reg;
    logic [tldr_pkg::TIME_W-1:0] arr_reg;
    logic [ENTRY_W-1:0]          src_rd_reg;
    logic [ENTRY_W-1:0]          dst_rd_reg;
    logic [tldr_pkg::ADDR_W-1:0] cnt_reg;

    logic                                joins_reg;
    logic                                joins_next;
    logic signed [tldr_pkg::STORE_W-1:0] time_reg;
    logic signed [tldr_pkg::STORE_W-1:0] time_next;

    logic                                wr_en;
    logic [tldr_pkg::ADDR_W-1:0]         wr_addr;
    logic [ENTRY_W-1:0]                  wr_data;

    logic signed [tldr_pkg::STORE_W-1:0] src_time;
    logic signed [tldr_pkg::STORE_W-1:0] dst_time;
    logic signed [tldr_pkg::STORE_W-1:0] dep_s;
    logic signed [tldr_pkg::STORE_W-1:0] arr_s;
    logic                                dst_visited;
    logic                                src_ok;
    logic                                raise;
    logic                                hit_target;
    logic                                result_load;

    assign src_time = $signed(src_rd_reg[tldr_pkg::STORE_W-1:0]);
    assign dst_time = $signed(dst_rd_reg[tldr_pkg::STORE_W-1:0]);
    assign dst_visited = dst_rd_reg[tldr_pkg::STORE_W];
    assign dep_s = $signed({1'b0, dep_reg});
    assign arr_s = $signed({1'b0, arr_reg});

    assign src_ok = src_time[tldr_pkg::STORE_W-1] || (arr_s <= src_time);
    assign raise = (dep_reg >= win_start_reg) && src_ok && (dep_s > dst_time);
    assign hit_target = (cnt_reg == target_reg[tldr_pkg::ADDR_W-1:0]);
    assign status.sweep_last = (cnt_reg == tldr_pkg::ADDR_W'(tldr_pkg::VERTEX_COUNT - 1));

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            win_start_reg <= '0;
            win_end_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tldr_pkg::CFG_TARGET:       target_reg <= cfg_data[tldr_pkg::VTX_W-1:0];
                tldr_pkg::CFG_WINDOW_START: win_start_reg <= cfg_data;
                tldr_pkg::CFG_WINDOW_END:   win_end_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            dst_reg <= dest_vertex;
            dep_reg <= edge_departure;
            arr_reg <= edge_arrival;
        end
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = dst_reg[tldr_pkg::ADDR_W-1:0];
        wr_data = dst_rd_reg;
        joins_next = 1'b0;
        time_next = dst_time;
        result_load = 1'b0;
        if (cmd.sweep)
        begin
            wr_en = 1'b1;
            wr_addr = cnt_reg;
            if (cmd.load_target && hit_target)
            begin
                wr_data = {1'b0, 1'b0, win_end_reg};
            end
            else
            begin
                wr_data = {1'b0, tldr_pkg::UNSET_TIME};
            end
            result_load = cmd.load_target && status.sweep_last;
            if (dst_reg == target_reg)
            begin
                time_next = $signed({1'b0, win_end_reg});
            end
            else
            begin
                time_next = tldr_pkg::UNSET_TIME;
            end
        end
        else if (cmd.eval)
        begin
            result_load = 1'b1;
            case (kind_reg)
                tldr_pkg::KIND_RELAX:
                begin
                    if (raise)
                    begin
                        wr_en = 1'b1;
                        wr_data = {1'b1, dep_s};
                        joins_next = !dst_visited;
                        time_next = dep_s;
                    end
                end
                tldr_pkg::KIND_CLEAR:
                begin
                    wr_en = 1'b1;
                    wr_data = {1'b0, dst_time};
                end
                default:
                begin
                end
            endcase
        end
    end

    // time store with visited mark in the top bit
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        src_rd_reg <= mem[source_vertex[tldr_pkg::ADDR_W-1:0]];
        dst_rd_reg <= mem[dest_vertex[tldr_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            joins_reg <= joins_next;
            time_reg <= time_next;
        end
    end

    assign joins_frontier = joins_reg;
    assign vertex_time = time_reg;

endmodule

// File: hw/rtl/temporal_latest_departure_relax_top.sv
// latest-departure relaxation engine over reversed temporal edges
// input: an item is taken on a clock edge with start high and busy low;
//   kind selects begin query, relax edge, clear visited mark or read time
// config: cfg_write with cfg_index (0 target, 1 window start, 2 window end)
//   and cfg_data; write only while busy is low and no result is pending
// output: done is high for one cycle with joins_frontier and vertex_time;
//   the receiver cannot stall, every result is taken in its cycle
// relax, clear and read: accept edge reads source and destination entries,
//   next edge writes any update back, registers the result and raises done;
//   the next item can be taken while done is high, not before
// begin: clearing pass over all 65536 store entries, one entry per cycle,
//   loading the target with the window end; done follows the last entry
// reset: the same clearing pass runs without loading a target; busy stays
//   high until the pass ends, config writes are still taken
// the time store is one memory with two read ports and one write port
module temporal_latest_departure_relax_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          kind,
    input  logic [tldr_pkg::VTX_W-1:0]          source_vertex,
    input  logic [tldr_pkg::VTX_W-1:0]          dest_vertex,
    input  logic [tldr_pkg::TIME_W-1:0]         edge_departure,
    input  logic [tldr_pkg::TIME_W-1:0]         edge_arrival,
    output logic                                done,
    output logic                                joins_frontier,
    output logic signed [tldr_pkg::STORE_W-1:0] vertex_time,
    input  logic                                cfg_write,
    input  logic [tldr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tldr_pkg::TIME_W-1:0]         cfg_data
);

    tldr_pkg::cmd_t    cmd;
    tldr_pkg::status_t status;

    tldr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tldr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .source_vertex  (source_vertex),
        .dest_vertex    (dest_vertex),
        .edge_departure (edge_departure),
        .edge_arrival   (edge_arrival),
        .joins_frontier (joins_frontier),
        .vertex_time    (vertex_time)
    );

endmodule

// File: sim/temporal_latest_departure_relax_top_tb.sv
module temporal_latest_departure_relax_top_tb;
    import tldr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = 31'h7FFFFFFF;
    localparam int STALL_LIMIT = 4 * VERTEX_COUNT;
    localparam int PHASE_ITEMS = 110;

    typedef struct packed {
        logic                       joins;
        logic signed [STORE_W-1:0]  vtime;
    } result_t;

    typedef struct packed {
        bit                 new_cfg;
        logic [1:0]         kind;
        logic [VTX_W-1:0]   src;
        logic [VTX_W-1:0]   dst;
        logic [TIME_W-1:0]  dep;
        logic [TIME_W-1:0]  arr;
        bit                 typed;
        result_t            want;
    } row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 kind = KIND_READ;
    logic [VTX_W-1:0]           source_vertex = '0;
    logic [VTX_W-1:0]           dest_vertex = '0;
    logic [TIME_W-1:0]          edge_departure = '0;
    logic [TIME_W-1:0]          edge_arrival = '0;
    logic                       done;
    logic                       joins_frontier;
    logic signed [STORE_W-1:0]  vertex_time;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [TIME_W-1:0]          cfg_data = '0;

    logic [VTX_W-1:0]           target_q = '0;
    logic [TIME_W-1:0]          window_lo = '0;
    logic [TIME_W-1:0]          window_hi = '0;
    logic signed [STORE_W-1:0]  departure_of [bit [VTX_W-1:0]];
    bit                         marked [bit [VTX_W-1:0]];
    result_t                    expected_results [$];
    int                         fail_count = 0;
    int                         stall_cycles = 0;
    bit                         quiet = 1'b0;

    row_t directed [22] = '{
        '{1'b0, KIND_READ,  16'd0,    16'h1234, 31'd0,        31'd0,    1'b1, '{1'b0, UNSET_TIME}},
        '{1'b0, KIND_RELAX, 16'd5,    16'd6,    31'd100,      31'd50,   1'b1, '{1'b1, 32'sd100}},
        '{1'b0, KIND_RELAX, 16'd5,    16'd6,    31'd100,      31'd50,   1'b1, '{1'b0, 32'sd100}},
        '{1'b0, KIND_RELAX, 16'd6,    16'd7,    31'd80,       31'd100,  1'b0, '0},
        '{1'b0, KIND_RELAX, 16'd6,    16'd7,    31'd90,       31'd101,  1'b0, '0},
        '{1'b0, KIND_READ,  16'd0,    16'd7,    31'd0,        31'd0,    1'b0, '0},
        '{1'b0, KIND_CLEAR, 16'd0,    16'd6,    31'd0,        31'd0,    1'b1, '{1'b0, 32'sd100}},
        '{1'b0, KIND_RELAX, 16'd5,    16'd6,    31'd200,      31'd0,    1'b0, '0},
        '{1'b0, KIND_RELAX, 16'd5,    16'd6,    31'd300,      31'd0,    1'b0, '0},
        '{1'b0, KIND_RELAX, 16'd9,    16'd9,    31'd10,       31'd0,    1'b1, '{1'b1, 32'sd10}},
        '{1'b0, KIND_RELAX, 16'd9,    16'd9,    31'd20,       31'd10,   1'b0, '0},
        '{1'b0, KIND_RELAX, 16'd9,    16'd9,    31'd30,       31'd21,   1'b0, '0},
        '{1'b0, KIND_RELAX, 16'hFFFF, 16'hFFFF, TIME_MAX,     TIME_MAX, 1'b1,
          '{1'b1, 32'sh7FFFFFFF}},
        '{1'b0, KIND_RELAX, 16'd0,    16'd0,    31'd0,        31'd0,    1'b1, '{1'b1, 32'sd0}},
        '{1'b0, KIND_READ,  16'd0,    16'hFFFF, 31'd0,        31'd0,    1'b1,
          '{1'b0, 32'sh7FFFFFFF}},
        '{1'b0, KIND_BEGIN, 16'hFFFF, 16'hFFFF, TIME_MAX,     TIME_MAX, 1'b1, '{1'b0, UNSET_TIME}},
        '{1'b0, KIND_READ,  16'd0,    16'd0,    31'd0,        31'd0,    1'b1, '{1'b0, 32'sd0}},
        '{1'b0, KIND_RELAX, 16'd0,    16'd1,    31'd0,        31'd0,    1'b0, '0},
        '{1'b0, KIND_CLEAR, 16'd0,    16'hFFFF, 31'd0,        31'd0,    1'b1, '{1'b0, UNSET_TIME}},
        '{1'b1, KIND_BEGIN, 16'd0,    16'hFFFF, 31'd0,        31'd0,    1'b1,
          '{1'b0, 32'sh7FFFFFFF}},
        '{1'b0, KIND_RELAX, 16'hFFFF, 16'd3,    31'h7FFFFFFE, 31'd0,    1'b1, '{1'b0, UNSET_TIME}},
        '{1'b0, KIND_RELAX, 16'hFFFF, 16'd3,    TIME_MAX,     TIME_MAX, 1'b1,
          '{1'b1, 32'sh7FFFFFFF}}
    };

    temporal_latest_departure_relax_top dut (.*);

    always #6 clk = ~clk;

    function automatic logic signed [STORE_W-1:0] stored_time(input logic [VTX_W-1:0] v);
        return departure_of.exists(v) ? departure_of[v] : UNSET_TIME;
    endfunction

    // updates the vertex times and marks for one item, returns its result
    function automatic result_t relax_step(input logic [1:0] k,
                                           input logic [VTX_W-1:0] src,
                                           input logic [VTX_W-1:0] dst,
                                           input logic [TIME_W-1:0] dep,
                                           input logic [TIME_W-1:0] arr);
        logic signed [STORE_W-1:0] src_time;
        logic signed [STORE_W-1:0] dep_t;
        logic signed [STORE_W-1:0] arr_t;
        result_t res;
        res = '0;
        dep_t = {1'b0, dep};
        arr_t = {1'b0, arr};
        case (k)
            KIND_BEGIN:
            begin
                departure_of.delete();
                marked.delete();
                departure_of[target_q] = {1'b0, window_hi};
            end
            KIND_RELAX:
            begin
                src_time = stored_time(src);
                if (dep >= window_lo && (src_time < 0 || arr_t <= src_time)
                        && dep_t > stored_time(dst))
                begin
                    departure_of[dst] = dep_t;
                    if (!marked.exists(dst))
                    begin
                        marked[dst] = 1'b1;
                        res.joins = 1'b1;
                    end
                end
            end
            KIND_CLEAR:
                marked.delete(dst);
            default:
            begin
            end
        endcase
        res.vtime = stored_time(dst);
        return res;
    endfunction

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0 || busy);
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [VTX_W-1:0] tgt,
                                 input logic [TIME_W-1:0] lo,
                                 input logic [TIME_W-1:0] hi);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_TARGET;
        cfg_data <= TIME_W'(tgt);
        @(posedge clk);
        cfg_index <= CFG_WINDOW_START;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= CFG_WINDOW_END;
        cfg_data <= hi;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data <= TIME_W'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        target_q = tgt;
        window_lo = lo;
        window_hi = hi;
    endtask

    task automatic send_item(input logic [1:0] k,
                             input logic [VTX_W-1:0] src,
                             input logic [VTX_W-1:0] dst,
                             input logic [TIME_W-1:0] dep,
                             input logic [TIME_W-1:0] arr,
                             input bit typed,
                             input result_t want);
        bit taken;
        result_t predicted;
        start <= 1'b1;
        kind <= k;
        source_vertex <= src;
        dest_vertex <= dst;
        edge_departure <= dep;
        edge_arrival <= arr;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        predicted = relax_step(k, src, dst, dep, arr);
        expected_results.push_back(typed ? want : predicted);
        if (!quiet && $urandom_range(0, 99) < 15)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        result_t exp_r;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                $display("%0t unexpected result: joins %0d time %0d",
                         $time, joins_frontier, vertex_time);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (joins_frontier !== exp_r.joins)
                begin
                    fail_count++;
                    $display("%0t joins_frontier: expected %0d actual %0d",
                             $time, exp_r.joins, joins_frontier);
                end
                if (vertex_time !== exp_r.vtime)
                begin
                    fail_count++;
                    $display("%0t vertex_time: expected %0d actual %0d",
                             $time, exp_r.vtime, vertex_time);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int p;
        int i;
        int r;
        int st;
        logic [1:0] k;
        logic [VTX_W-1:0] s;
        logic [VTX_W-1:0] d;
        logic [TIME_W-1:0] dp;
        logic [TIME_W-1:0] ar;
        logic [VTX_W-1:0] pool [16];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        load_settings(16'd0, 31'd0, 31'd0);
        foreach (directed[n])
        begin
            if (directed[n].new_cfg)
                load_settings(16'hFFFF, TIME_MAX, TIME_MAX);
            send_item(directed[n].kind, directed[n].src, directed[n].dst, directed[n].dep,
                      directed[n].arr, directed[n].typed, directed[n].want);
        end

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0: load_settings(VTX_W'($urandom), 31'd1000, 31'd3000);
                1: load_settings(16'd0, 31'd0, TIME_MAX);
                2:
                begin
                    r = $urandom_range(0, 32'h3FFFFFFF);
                    load_settings(VTX_W'($urandom), TIME_W'(r),
                                  TIME_W'(r + $urandom_range(0, 5000)));
                end
                default: load_settings(16'hFFFF, 31'h7FFFF000, TIME_MAX);
            endcase
            quiet = (p == 1);
            // small working set so edges chain through vertices with known times
            pool[0] = target_q;
            for (i = 1; i < 16; i++)
                pool[i] = (i < 8) ? VTX_W'($urandom_range(0, 31)) : VTX_W'($urandom);
            send_item(KIND_BEGIN, VTX_W'($urandom), pool[$urandom_range(0, 15)],
                      TIME_W'($urandom), TIME_W'($urandom), 1'b0, '0);

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                s = pool[$urandom_range(0, 15)];
                d = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 15)]
                                                 : VTX_W'($urandom);
                dp = TIME_W'($urandom);
                ar = TIME_W'($urandom);
                k = KIND_RELAX;
                if (r < 10)
                begin
                    k = 2'($urandom_range(1, 3));
                    s = VTX_W'($urandom);
                    d = VTX_W'($urandom);
                end
                else if (r < 65)
                begin
                    if ($urandom_range(0, 9) == 0 && window_lo > 50)
                        dp = window_lo - TIME_W'($urandom_range(1, 50));
                    else
                        dp = TIME_W'($urandom_range(window_lo, window_hi));
                    st = stored_time(s);
                    if (st >= 0)
                    begin
                        // mostly arrivals the source can still make, some just too late
                        if ($urandom_range(0, 99) < 15)
                            ar = (st < int'(TIME_MAX) - 50)
                                 ? TIME_W'(st + $urandom_range(1, 50)) : TIME_W'(st);
                        else
                            ar = TIME_W'(st - $urandom_range(0, (st < 500) ? st : 500));
                    end
                end
                else if (r < 80)
                    k = KIND_CLEAR;
                else
                    k = KIND_READ;
                send_item(k, s, d, dp, ar, 1'b0, '0);
                if ($urandom_range(0, 99) < 2)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tldr_pkg.sv
hw/rtl/tldr_ctrl.sv
hw/rtl/tldr_datapath.sv
hw/rtl/temporal_latest_departure_relax_top.sv
sim/temporal_latest_departure_relax_top_tb.sv
